>>> src/http_response_body_framer_top_defines.svh
// Assertion macros for the HTTP response body framer.
// Included by the top level; no other dependencies.
`ifndef HTTP_RESPONSE_BODY_FRAMER_TOP_DEFINES_SVH
`define HTTP_RESPONSE_BODY_FRAMER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Temporal check, disabled while reset is asserted.
`define HRBF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Invariant that must hold at every clock edge outside reset.
`define HRBF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define HRBF_ASSERT(label, clk, rst_n, prop, msg)
`define HRBF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`endif
`endif

>>> src/hrbf_pkg.sv
// Shared types, character constants and helpers for the response body framer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hrbf_pkg;

    // ASCII characters recognized by the parser.
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_LIMIT = 2'd1;
    localparam int unsigned CFG_DATA_W = 12;

    // Field widths.
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned HDR_LIM_W   = 12;
    localparam int unsigned BODY_LIM_W  = 10;
    localparam int unsigned BYTE_CNT_W  = 13;
    localparam int unsigned INDEX_W     = 9;
    localparam int unsigned LENGTH_W    = 10;

    localparam logic [HDR_LIM_W-1:0]  HDR_LIMIT_RESET  = 12'd1024;
    localparam logic [BODY_LIM_W-1:0] BODY_LIMIT_RESET = 10'd512;

    // Last step of the version text match.
    localparam logic [2:0] VERSION_LAST = 3'd7;

    typedef enum logic [1:0] {
        PH_VERSION = 2'd0,
        PH_CODE    = 2'd1,
        PH_BODY    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SUB_FIND = 2'd0,
        SUB_RECV = 2'd1,
        SUB_TAIL = 2'd2
    } t_sub;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_BAD     = 2'd1,
        KIND_CREATED = 2'd2,
        KIND_DONE    = 2'd3
    } t_kind;

    // Parser control state that does not depend on the body depth.
    typedef struct packed {
        t_phase                phase;
        logic [2:0]            match_step;
        t_sub                  sub;
        logic [BYTE_CNT_W-1:0] byte_count;
    } t_ctrl;

    // One result transaction.
    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   value;
        logic [INDEX_W-1:0]  index;
        logic [LENGTH_W-1:0] length;
    } t_result;

    localparam t_ctrl CTRL_RESET = '{
        phase:      PH_VERSION,
        match_step: 3'd0,
        sub:        SUB_FIND,
        byte_count: 13'd0
    };

    // Expected character of the version text "HTTP/1.1" at a given step.
    function automatic logic [7:0] version_char(input logic [2:0] step);
        logic [7:0] ch;
        unique case (step)
            3'd0: ch = CH_H;
            3'd1: ch = CH_T;
            3'd2: ch = CH_T;
            3'd3: ch = CH_P;
            3'd4: ch = CH_SLASH;
            3'd5: ch = CH_ONE;
            3'd6: ch = CH_DOT;
            3'd7: ch = CH_ONE;
            default: ch = CH_H;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> src/http_response_body_framer_top.sv
// Top level of the HTTP response body framer: input stage, parser, result register.
// Depends on hrbf_pkg, hrbf_in_stage, hrbf_step and the assertion macro header.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_rx_byte) takes one response byte per
//   transaction. Output channel (o_out_valid / i_out_ready) gives zero or one result
//   per byte: a body byte with its index, bad request, created, or body complete
//   with its length. Configuration channel (i_cfg_valid / o_cfg_ready) writes the
//   header byte limit (index 0) and the body length limit (index 1); it is always
//   ready. The user must write it only while no byte is in flight; the block
//   itself does not enforce this. A byte is accepted into the input register;
//   its outcome is then loaded into the result register, which drives the output.
//   Bytes flow at one byte per cycle unless a held result blocks them; the parser
//   state update is a single pass of compare and counter logic.
//   When the receiver stalls, the held result waits in the result register; bytes
//   that give no result keep flowing, and a byte that gives a result waits in the
//   input register, which then drops o_in_ready.
//   Reset clears the parser to the version-match phase, empties both registers and
//   restores the limits to 1024 header bytes and 512 body bytes.
`timescale 1ns / 1ps
`default_nettype none
`include "http_response_body_framer_top_defines.svh"

module http_response_body_framer_top #(
    parameter int unsigned BODY_DEPTH = 512
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [hrbf_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [1:0]                               o_result_kind,
    output logic [hrbf_pkg::BYTE_W-1:0]              o_body_value,
    output logic [hrbf_pkg::INDEX_W-1:0]             o_body_index,
    output logic [hrbf_pkg::LENGTH_W-1:0]            o_body_length,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [hrbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hrbf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import hrbf_pkg::*;

    localparam int unsigned CW = $clog2(BODY_DEPTH + 1);

    logic                  stg_valid;
    logic [BYTE_W-1:0]     stg_byte;
    logic                  advance;

    t_ctrl                 r_ctrl;
    logic [CW-1:0]         r_body_count;
    logic [CW-1:0]         r_brace_depth;
    logic [HDR_LIM_W-1:0]  r_hdr_limit;
    logic [BODY_LIM_W-1:0] r_body_limit;
    logic                  r_out_valid;
    t_result               r_out;

    t_ctrl                 n_ctrl;
    logic [CW-1:0]         n_body_count;
    logic [CW-1:0]         n_brace_depth;
    logic                  step_has_result;
    t_result               n_out;

    // Input register stage.
    hrbf_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_rx_byte  (i_rx_byte),
        .i_take     (advance),
        .o_valid    (stg_valid),
        .o_byte     (stg_byte)
    );

    // Parser logic for the byte held in the input stage.
    hrbf_step #(
        .BODY_DEPTH (BODY_DEPTH),
        .CW         (CW)
    ) u_step (
        .i_rx_byte     (stg_byte),
        .i_ctrl        (r_ctrl),
        .i_body_count  (r_body_count),
        .i_brace_depth (r_brace_depth),
        .i_hdr_limit   (r_hdr_limit),
        .i_body_limit  (r_body_limit),
        .o_ctrl        (n_ctrl),
        .o_body_count  (n_body_count),
        .o_brace_depth (n_brace_depth),
        .o_has_result  (step_has_result),
        .o_result      (n_out)
    );

    // A byte is processed unless its result would overwrite a stalled one.
    assign advance = stg_valid && (!step_has_result || !r_out_valid || i_out_ready);

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl        <= CTRL_RESET;
            r_body_count  <= '0;
            r_brace_depth <= '0;
        end else if (advance) begin
            r_ctrl        <= n_ctrl;
            r_body_count  <= n_body_count;
            r_brace_depth <= n_brace_depth;
        end
    end

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_limit  <= HDR_LIMIT_RESET;
            r_body_limit <= BODY_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_HDR_LIMIT) begin
                r_hdr_limit <= i_cfg_data[HDR_LIM_W-1:0];
            end else if (i_cfg_index == REG_BODY_LIMIT) begin
                r_body_limit <= i_cfg_data[BODY_LIM_W-1:0];
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (advance && step_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out.kind;
    assign o_body_value  = r_out.value;
    assign o_body_index  = r_out.index;
    assign o_body_length = r_out.length;

    // The body counter never runs past the buffer depth.
    `HRBF_ASSERT_ALWAYS(a_body_count_range, i_clk, i_rst_n, r_body_count <= CW'(BODY_DEPTH), "body count beyond buffer depth")

    // Every open brace is counted as a body byte, so depth never exceeds the count.
    `HRBF_ASSERT_ALWAYS(a_depth_le_count, i_clk, i_rst_n, r_brace_depth <= r_body_count, "brace depth exceeds body count")

    // A final result returns the parser to its reset state.
    `HRBF_ASSERT(a_final_clears, i_clk, i_rst_n, (advance && step_has_result && n_out.kind != KIND_BYTE) |=> (r_ctrl == CTRL_RESET && r_body_count == '0 && r_brace_depth == '0), "final result did not clear parser state")

    // A result that is held back never lets its byte leave the input stage.
    `HRBF_ASSERT(a_stall_holds_byte, i_clk, i_rst_n, (stg_valid && step_has_result && r_out_valid && !i_out_ready) |=> (stg_valid && $stable(stg_byte) && $stable(r_ctrl)), "stalled byte was consumed")

endmodule

`default_nettype wire

>>> src/hrbf_in_stage.sv
// Input register stage of the response body framer: holds one received byte.
// Depends on hrbf_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

module hrbf_in_stage (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [hrbf_pkg::BYTE_W-1:0] i_rx_byte,
    input  wire logic                      i_take,
    output logic                           o_valid,
    output logic [hrbf_pkg::BYTE_W-1:0]    o_byte
);
    import hrbf_pkg::*;

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;

    // The stage can load whenever it is empty or its byte leaves this cycle.
    assign o_in_ready = !r_valid || i_take;

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    // Byte register; loads on every accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

`default_nettype wire

>>> src/hrbf_step.sv
// Per-byte parser logic: next state and optional result for one byte.
// Depends on hrbf_pkg for types, characters and the version text.
`timescale 1ns / 1ps
`default_nettype none

module hrbf_step #(
    parameter int unsigned BODY_DEPTH = 512,
    parameter int unsigned CW         = $clog2(BODY_DEPTH + 1)
) (
    input  wire logic [hrbf_pkg::BYTE_W-1:0]     i_rx_byte,
    input  wire hrbf_pkg::t_ctrl                 i_ctrl,
    input  wire logic [CW-1:0]                   i_body_count,
    input  wire logic [CW-1:0]                   i_brace_depth,
    input  wire logic [hrbf_pkg::HDR_LIM_W-1:0]  i_hdr_limit,
    input  wire logic [hrbf_pkg::BODY_LIM_W-1:0] i_body_limit,
    output hrbf_pkg::t_ctrl                      o_ctrl,
    output logic [CW-1:0]                        o_body_count,
    output logic [CW-1:0]                        o_brace_depth,
    output logic                                 o_has_result,
    output hrbf_pkg::t_result                    o_result
);
    import hrbf_pkg::*;

    localparam int unsigned CMPW = (CW > BODY_LIM_W) ? CW : BODY_LIM_W;
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(BODY_DEPTH);

    logic                  hdr_over_gt;
    logic                  hdr_over_ge;
    logic                  body_full;
    logic                  len_reject;
    logic [BYTE_CNT_W-1:0] cnt_inc;

    // Limit comparisons used by the phases.
    assign hdr_over_gt = i_ctrl.byte_count >  {1'b0, i_hdr_limit};
    assign hdr_over_ge = i_ctrl.byte_count >= {1'b0, i_hdr_limit};
    assign body_full   = i_body_count >= CNT_FULL;
    assign len_reject  = CMPW'(i_body_count) >= CMPW'(i_body_limit);
    assign cnt_inc     = i_ctrl.byte_count + 13'd1;

    // Phase decoder.
    always_comb begin
        logic clr;
        clr           = 1'b0;
        o_ctrl        = i_ctrl;
        o_body_count  = i_body_count;
        o_brace_depth = i_brace_depth;
        o_has_result  = 1'b0;
        o_result      = '0;

        unique case (i_ctrl.phase)
            PH_VERSION: begin
                if (hdr_over_gt) begin
                    o_has_result  = 1'b1;
                    o_result.kind = KIND_BAD;
                    clr           = 1'b1;
                end else begin
                    o_ctrl.byte_count = cnt_inc;
                    if (i_ctrl.match_step == 3'd0) begin
                        // Anything but 'H' restarts the count of header bytes.
                        if (i_rx_byte == CH_H) begin
                            o_ctrl.match_step = 3'd1;
                        end else begin
                            o_ctrl.byte_count = '0;
                        end
                    end else if (i_rx_byte == version_char(i_ctrl.match_step)) begin
                        if (i_ctrl.match_step == VERSION_LAST) begin
                            o_ctrl.phase      = PH_CODE;
                            o_ctrl.match_step = 3'd0;
                        end else begin
                            o_ctrl.match_step = i_ctrl.match_step + 3'd1;
                        end
                    end
                end
            end

            PH_CODE: begin
                if (hdr_over_ge) begin
                    o_has_result  = 1'b1;
                    o_result.kind = KIND_BAD;
                    clr           = 1'b1;
                end else begin
                    o_ctrl.byte_count = cnt_inc;
                    if (i_ctrl.match_step == 3'd0) begin
                        if (i_rx_byte == CH_FOUR || i_rx_byte == CH_FIVE) begin
                            o_has_result  = 1'b1;
                            o_result.kind = KIND_BAD;
                            clr           = 1'b1;
                        end else if (i_rx_byte == CH_TWO) begin
                            o_ctrl.match_step = 3'd1;
                        end
                    end else if (i_ctrl.match_step == 3'd1) begin
                        if (i_rx_byte == CH_ZERO) begin
                            o_ctrl.match_step = 3'd2;
                        end
                    end else begin
                        // Third digit: 201 is created, 200 carries a body.
                        if (i_rx_byte == CH_ONE) begin
                            o_has_result  = 1'b1;
                            o_result.kind = KIND_CREATED;
                            clr           = 1'b1;
                        end else if (i_rx_byte == CH_ZERO) begin
                            o_ctrl.phase = PH_BODY;
                        end
                    end
                end
            end

            PH_BODY: begin
                if (hdr_over_ge) begin
                    o_has_result  = 1'b1;
                    o_result.kind = KIND_BAD;
                    clr           = 1'b1;
                end else begin
                    o_ctrl.byte_count = cnt_inc;
                    unique case (i_ctrl.sub)
                        SUB_FIND, SUB_RECV: begin
                            if (i_ctrl.sub == SUB_FIND || i_brace_depth != '0) begin
                                // Skip bytes before the opening brace.
                                if (i_ctrl.sub == SUB_FIND && i_rx_byte != CH_LBRACE) begin
                                    o_has_result = 1'b0;
                                end else begin
                                    o_ctrl.sub = SUB_RECV;
                                    if (i_rx_byte == CH_LBRACE) begin
                                        o_brace_depth = i_brace_depth + CNT_ONE;
                                    end else if (i_rx_byte == CH_RBRACE) begin
                                        o_brace_depth = i_brace_depth - CNT_ONE;
                                    end
                                    // A full body buffer rejects the response.
                                    if (body_full) begin
                                        o_has_result  = 1'b1;
                                        o_result.kind = KIND_BAD;
                                        clr           = 1'b1;
                                    end else begin
                                        o_has_result   = 1'b1;
                                        o_result.kind  = KIND_BYTE;
                                        o_result.value = i_rx_byte;
                                        o_result.index = INDEX_W'(i_body_count);
                                        o_body_count   = i_body_count + CNT_ONE;
                                    end
                                end
                            end else begin
                                // Depth back at zero: this byte moves to the tail, and the next one closes the body.
                                o_ctrl.sub = SUB_TAIL;
                            end
                        end
                        default: begin
                            o_has_result = 1'b1;
                            clr          = 1'b1;
                            if (len_reject) begin
                                o_result.kind = KIND_BAD;
                            end else begin
                                o_result.kind   = KIND_DONE;
                                o_result.length = LENGTH_W'(i_body_count);
                            end
                        end
                    endcase
                end
            end

            default: begin
                // Unused phase code: silently return to reset state.
                clr = 1'b1;
            end
        endcase

        // Any final result or bad state returns the parser to its reset state.
        if (clr) begin
            o_ctrl        = CTRL_RESET;
            o_body_count  = '0;
            o_brace_depth = '0;
        end
    end

endmodule

`default_nettype wire

>>> sim/http_response_body_framer_checker.sv
// Scoreboard for the HTTP response body framer: watches the byte, result and
// register channels, predicts each result and compares it field by field.
// Depends on hrbf_pkg for the character constants, register indexes and result types.
`timescale 1ns / 1ps

module http_response_body_framer_checker #(
    parameter int unsigned BODY_DEPTH = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [hrbf_pkg::BYTE_W-1:0]         i_rx_byte,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [1:0]                          i_result_kind,
    input  logic [hrbf_pkg::BYTE_W-1:0]         i_body_value,
    input  logic [hrbf_pkg::INDEX_W-1:0]        i_body_index,
    input  logic [hrbf_pkg::LENGTH_W-1:0]       i_body_length,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [hrbf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hrbf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import hrbf_pkg::*;

    localparam logic [63:0] VERSION_TEXT = "HTTP/1.1";

    // Predicted parser state and register copies.
    t_phase                 resp_phase;
    logic [2:0]             match_pos;
    t_sub                   body_state;
    int unsigned            body_len;
    int unsigned            nest_depth;
    int unsigned            hdr_bytes;
    logic [HDR_LIM_W-1:0]   hdr_limit;
    logic [BODY_LIM_W-1:0]  len_limit;

    // Results predicted but not yet seen on the output channel.
    t_result                awaited_results[$];
    int                     fails = 0;

    // Every mismatch goes through here: one line each, and it is counted.
    task automatic log_mismatch(input string msg);
        fails++;
        $display("%0t MISMATCH %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
        end
    endtask

    // A bad, created or done result sends the parser back to its reset state.
    task automatic restart_parse();
        resp_phase = PH_VERSION;
        match_pos  = 3'd0;
        body_state = SUB_FIND;
        body_len   = 0;
        nest_depth = 0;
        hdr_bytes  = 0;
    endtask

    task automatic finish_response(input t_kind kind, input int unsigned length,
                                   output bit made, output t_result res);
        restart_parse();
        made       = 1'b1;
        res        = '0;
        res.kind   = kind;
        res.length = length[LENGTH_W-1:0];
    endtask

    // Emits one body byte, or a bad request when the body store is full.
    task automatic store_body_byte(input logic [7:0] b, output bit made,
                                   output t_result res);
        if (body_len >= BODY_DEPTH) begin
            finish_response(KIND_BAD, 0, made, res);
        end else begin
            made      = 1'b1;
            res       = '0;
            res.kind  = KIND_BYTE;
            res.value = b;
            res.index = body_len[INDEX_W-1:0];
            body_len++;
        end
    endtask

    // Advances the predicted parser by one byte and tells whether it gives a result.
    task automatic frame_byte(input logic [7:0] b, output bit made, output t_result res);
        made = 1'b0;
        res  = '0;
        case (resp_phase)
            PH_VERSION: begin
                if (hdr_bytes > hdr_limit) begin
                    finish_response(KIND_BAD, 0, made, res);
                end else begin
                    hdr_bytes++;
                    if (match_pos == 3'd0) begin
                        if (b == CH_H) match_pos = 3'd1;
                        else hdr_bytes = 0;
                    end else if (b == VERSION_TEXT[63 - 8 * match_pos -: 8]) begin
                        if (match_pos == VERSION_LAST) begin
                            resp_phase = PH_CODE;
                            match_pos  = 3'd0;
                        end else begin
                            match_pos++;
                        end
                    end
                end
            end
            PH_CODE: begin
                if (hdr_bytes >= hdr_limit) begin
                    finish_response(KIND_BAD, 0, made, res);
                end else begin
                    hdr_bytes++;
                    if (match_pos == 3'd0) begin
                        if (b == CH_FOUR || b == CH_FIVE) begin
                            finish_response(KIND_BAD, 0, made, res);
                        end else if (b == CH_TWO) begin
                            match_pos = 3'd1;
                        end
                    end else if (match_pos == 3'd1) begin
                        if (b == CH_ZERO) match_pos = 3'd2;
                    end else if (b == CH_ONE) begin
                        finish_response(KIND_CREATED, 0, made, res);
                    end else if (b == CH_ZERO) begin
                        resp_phase = PH_BODY;
                    end
                end
            end
            PH_BODY: begin
                if (hdr_bytes >= hdr_limit) begin
                    finish_response(KIND_BAD, 0, made, res);
                end else begin
                    hdr_bytes++;
                    case (body_state)
                        SUB_FIND: begin
                            if (b == CH_LBRACE) begin
                                body_state = SUB_RECV;
                                nest_depth++;
                                store_body_byte(b, made, res);
                            end
                        end
                        SUB_RECV: begin
                            // The first byte after the braces balance only moves to the tail.
                            if (nest_depth == 0) begin
                                body_state = SUB_TAIL;
                            end else begin
                                if (b == CH_LBRACE) nest_depth++;
                                else if (b == CH_RBRACE) nest_depth--;
                                store_body_byte(b, made, res);
                            end
                        end
                        default: begin
                            if (body_len >= len_limit) begin
                                finish_response(KIND_BAD, 0, made, res);
                            end else begin
                                finish_response(KIND_DONE, body_len, made, res);
                            end
                        end
                    endcase
                end
            end
            default: restart_parse();
        endcase
    endtask

    // Results are checked before new predictions are queued, so a result can
    // never be matched against a byte accepted at the same edge.
    always @(posedge i_clk) begin
        t_result want;
        t_result fresh;
        bit      made;
        if (!i_rst_n) begin
            restart_parse();
            hdr_limit = HDR_LIMIT_RESET;
            len_limit = BODY_LIMIT_RESET;
            awaited_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_results.size() == 0) begin
                    log_mismatch($sformatf("result of kind %0d with none expected",
                                           i_result_kind));
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("result_kind", 16'(i_result_kind), 16'(want.kind));
                    compare_field("body_value", 16'(i_body_value), 16'(want.value));
                    compare_field("body_index", 16'(i_body_index), 16'(want.index));
                    compare_field("body_length", 16'(i_body_length), 16'(want.length));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_HDR_LIMIT:  hdr_limit = i_cfg_data[HDR_LIM_W-1:0];
                    REG_BODY_LIMIT: len_limit = i_cfg_data[BODY_LIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                frame_byte(i_rx_byte, made, fresh);
                if (made) awaited_results.push_back(fresh);
            end
        end
        o_pending    <= awaited_results.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/tb_http_response_body_framer_top.sv
// Testbench top for the HTTP response body framer: clock, reset, response
// stimulus, register writes, output back-pressure and the final verdict.
// Depends on hrbf_pkg, http_response_body_framer_top and http_response_body_framer_checker.
`timescale 1ns / 1ps

module tb_http_response_body_framer_top;

    import hrbf_pkg::*;

    localparam int unsigned BODY_DEPTH    = 512;
    localparam logic [63:0] VERSION_TEXT  = "HTTP/1.1";
    localparam int          SETTLE_CYCLES = 4;
    localparam int          LONG_HOLD     = 200;
    localparam int          LIMIT_CYCLES  = 800000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    logic [BYTE_W-1:0]     rx_byte   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            result_kind;
    logic [BYTE_W-1:0]     body_value;
    logic [INDEX_W-1:0]    body_index;
    logic [LENGTH_W-1:0]   body_length;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int bytes_sent    = 0;
    int cycle_count   = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int stall_left    = 0;
    bit calm          = 1'b0;

    http_response_body_framer_top #(
        .BODY_DEPTH (BODY_DEPTH)
    ) u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_result_kind (result_kind),
        .o_body_value  (body_value),
        .o_body_index  (body_index),
        .o_body_length (body_length),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    http_response_body_framer_checker #(
        .BODY_DEPTH (BODY_DEPTH)
    ) u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_rx_byte     (rx_byte),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_result_kind (result_kind),
        .i_body_value  (body_value),
        .i_body_index  (body_index),
        .i_body_length (body_length),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // Idle length: mostly none or short, now and then long; none in calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Output back-pressure, with a long hold-off whenever the stimulus asks for one.
    initial begin
        forever begin
            @(posedge clk);
            if (holds_served < hold_requests) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                holds_served++;
            end else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end else begin
                out_ready  <= 1'b1;
                stall_left = ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
            end
        end
    end

    // One byte transaction, after a random idle gap.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // Stops offering bytes until every predicted result has been taken and
    // any byte without a result has cleared the pipeline.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A body with random content and nesting; forced closing braces at the
    // target, then the two trailing bytes that complete it, unless truncated.
    task automatic send_body(input int target, input bit truncate);
        int          depth;
        int          n;
        int          r;
        logic [7:0]  b;
        send_byte(CH_LBRACE);
        depth = 1;
        n = 1;
        while (depth > 0 && !(truncate && n >= target)) begin
            r = $urandom_range(0, 99);
            if (n >= target) b = CH_RBRACE;
            else if (r < 12 && depth < 6) b = CH_LBRACE;
            else if (r < 22 && depth > 1) b = CH_RBRACE;
            else b = 8'($urandom_range(0, 255));
            if (b == CH_LBRACE) depth++;
            else if (b == CH_RBRACE) depth--;
            send_byte(b);
            n++;
        end
        if (!truncate) begin
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // One response, mostly well formed. A nonzero body_target forces a 200
    // response with a body of at least that length.
    task automatic send_response(input int body_target);
        int k;
        int r;
        int target;
        repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        for (k = 0; k < 8; k++) begin
            if ($urandom_range(0, 99) < 3) send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) >= 2) send_byte(VERSION_TEXT[63 - 8 * k -: 8]);
        end
        r = (body_target > 0) ? 0 : $urandom_range(0, 99);
        if (r < 62) begin
            send_byte(CH_TWO);
            send_byte(CH_ZERO);
            send_byte(CH_ZERO);
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
            if (body_target > 0) begin
                target = body_target;
            end else begin
                k = $urandom_range(0, 99);
                if (k < 90) target = $urandom_range(1, 40);
                else if (k < 97) target = $urandom_range(41, 200);
                else target = $urandom_range(480, 530);
            end
            send_body(target, body_target == 0 && $urandom_range(0, 99) < 3);
        end else if (r < 76) begin
            send_byte(CH_TWO);
            send_byte(CH_ZERO);
            send_byte(CH_ONE);
        end else if (r < 84) begin
            send_byte($urandom_range(0, 1) ? CH_FOUR : CH_FIVE);
        end else begin
            // Odd status codes: stray digits after "2" and "20".
            send_byte(CH_TWO);
            send_byte($urandom_range(0, 1) ? CH_ZERO : 8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Holds the output off while a gap-free response keeps coming, so the
    // block fills up and drops its input ready.
    task automatic squeeze_pipeline();
        hold_requests++;
        calm = 1'b1;
        send_response(40);
        calm = 1'b0;
    endtask

    task automatic run_segment(input int n_bytes);
        int stop;
        stop = bytes_sent + n_bytes;
        while (bytes_sent < stop) begin
            calm = ($urandom_range(0, 99) < 12);
            if ($urandom_range(0, 99) < 3) drain_results();
            send_response(0);
        end
        calm = 1'b0;
    endtask

    // Main sequence: reset, directed responses, then random responses under
    // a series of limit settings.
    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Rejected code, then created with an ignored third digit.
        send_byte(8'h00);
        send_text("HTTP/1.1");
        send_byte(CH_FOUR);
        send_text("HTTP/1.1");
        send_byte(CH_TWO);
        send_byte(CH_ZERO);
        send_byte(8'hFF);
        send_byte(CH_ONE);
        run_segment(130);

        // Widest header limit lets the body store overflow.
        write_reg(REG_HDR_LIMIT, 12'd4095);
        write_reg(REG_BODY_LIMIT, 12'd512);
        send_response(520);
        squeeze_pipeline();
        run_segment(130);

        // Zero limits.
        write_reg(REG_HDR_LIMIT, 12'd0);
        write_reg(REG_BODY_LIMIT, 12'd0);
        run_segment(40);

        write_reg(REG_HDR_LIMIT, 12'd1);
        write_reg(REG_BODY_LIMIT, 12'd1);
        run_segment(60);

        // Tight limits; the header limit trips in the middle of bodies.
        write_reg(REG_HDR_LIMIT, 12'd40);
        write_reg(REG_BODY_LIMIT, 12'd10);
        squeeze_pipeline();
        run_segment(110);

        // Writes to an unused index and with bits beyond the register width.
        write_reg(REG_UNUSED, 12'($urandom_range(0, 4095)));
        write_reg(REG_BODY_LIMIT, 12'hFFF);
        write_reg(REG_HDR_LIMIT, 12'd2000);
        run_segment(70);

        repeat (2) begin
            write_reg(REG_HDR_LIMIT, 12'($urandom_range(12, 700)));
            write_reg(REG_BODY_LIMIT, 12'($urandom_range(1, 512)));
            run_segment(50);
        end

        drain_results();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

>>> http_response_body_framer_top.f
+incdir+src
src/hrbf_pkg.sv
src/hrbf_in_stage.sv
src/hrbf_step.sv
src/http_response_body_framer_top.sv
sim/http_response_body_framer_checker.sv
sim/tb_http_response_body_framer_top.sv
